@@ hw/rtl/plux_pkg.sv @@
// ============================================================================
// plux_pkg
// Shared widths, region codes, fit coefficients and the ratio power table
// for the two-channel piecewise lux unit.
// ============================================================================
package plux_pkg;

  localparam int unsigned FRACTION_BITS     = 8;
  localparam int unsigned POWER_TABLE_DEPTH = 256;

  localparam int unsigned CNT_W = 16;
  localparam int unsigned LUX_W = 23;
  localparam logic [LUX_W-1:0] LUX_MAX = '1;

  // ratio index: i = round(ch1 * 2*RATIO_N / (2*ch0)), RATIO_N = 2*depth
  localparam int unsigned RATIO_N = 2 * POWER_TABLE_DEPTH;
  localparam int unsigned IDX_W   = $clog2(POWER_TABLE_DEPTH + 1);
  localparam int unsigned TAB_W   = $clog2(POWER_TABLE_DEPTH);
  localparam int unsigned DVD_W   = CNT_W + $clog2(2 * RATIO_N + 1);
  localparam int unsigned DSR_W   = CNT_W + 1;
  localparam int unsigned DIV_W   = DVD_W + IDX_W;

  // power table entries are Q16
  localparam int unsigned POW_W  = 16;
  localparam int unsigned BIG_W  = 5 * (POW_W + 2) + 7 * ($clog2(RATIO_N) + 1) + 8;

  // lowest region: coef = 3040*2^16 - 6200*P, coefficients in units of 1e-5
  localparam int unsigned COEF_W = 28;
  localparam logic [COEF_W:0] POW_BASE  = (COEF_W+1)'(3040 * 65536);
  localparam logic [COEF_W:0] POW_SLOPE = (COEF_W+1)'(6200);

  // upper regions: lin = A*ch0 - B*ch1
  localparam int unsigned LIN_CW = 12;
  localparam int unsigned LIN_W  = CNT_W + LIN_CW + 1;
  localparam logic [LIN_CW-1:0] LIN_A61  = 12'd2240;
  localparam logic [LIN_CW-1:0] LIN_B61  = 12'd3100;
  localparam logic [LIN_CW-1:0] LIN_A80  = 12'd1280;
  localparam logic [LIN_CW-1:0] LIN_B80  = 12'd1530;
  localparam logic [LIN_CW-1:0] LIN_A130 = 12'd146;
  localparam logic [LIN_CW-1:0] LIN_B130 = 12'd112;

  // scaling and rounding: both divisors are 3125 times a power of two
  localparam int unsigned NUM_W    = COEF_W + CNT_W;
  localparam int unsigned SCALE_SH = 4 + FRACTION_BITS;
  localparam int unsigned X_W      = NUM_W + SCALE_SH + 1;
  localparam int unsigned POW_SH   = 21;
  localparam int unsigned LIN_SH   = 5;
  localparam int unsigned DIV_K    = 3125;
  localparam int unsigned KW       = $clog2(DIV_K + 1);
  localparam int unsigned Y_W      = KW + LUX_W;
  localparam logic [X_W-1:0] HALF_POW  = X_W'(64'd50000 << 16);
  localparam logic [X_W-1:0] HALF_LIN  = X_W'(64'd50000);
  localparam logic [X_W-1:0] SAT_LIMIT = X_W'(DIV_K) << LUX_W;

  // floor(y / 3125) = (y * RECIP) >> RECIP_SH for every y below 3125 * 2^LUX_W:
  // the rounding error of RECIP times the largest y stays below 2^RECIP_SH
  localparam int unsigned RECIP_SH = 46;
  localparam int unsigned RECIP_W  = 36;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(DIV_K) - 64'd1) / 64'(DIV_K));

  typedef enum logic [2:0] {
    REG_ZERO,
    REG_POW,
    REG_R61,
    REG_R80,
    REG_R130
  } region_e;

  typedef struct packed {
    logic [CNT_W-1:0] ch0;
    logic [CNT_W-1:0] ch1;
    region_e          region;
  } plux_side_t;

  // Largest y with y^5 * n^7 <= idx^7 * 2^80, i.e. floor(2^16 * (idx/n)^1.4).
  function automatic logic [POW_W-1:0] pow_entry(input int unsigned idx);
    logic [BIG_W-1:0] lhs;
    logic [BIG_W-1:0] rhs;
    logic [POW_W+1:0] lo;
    logic [POW_W+1:0] hi;
    logic [POW_W+1:0] mid;
    lo = '0;
    hi = (POW_W+2)'(1) << POW_W;
    for (int s = 0; s < POW_W + 2; s++) begin
      if (lo < hi) begin
        mid = (lo + hi + (POW_W+2)'(1)) >> 1;
        lhs = BIG_W'(1);
        rhs = BIG_W'(1);
        for (int k = 0; k < 5; k++) begin
          lhs = lhs * BIG_W'(mid);
          rhs = rhs << POW_W;
        end
        for (int k = 0; k < 7; k++) begin
          lhs = lhs * BIG_W'(RATIO_N);
          rhs = rhs * BIG_W'(idx);
        end
        if (lhs <= rhs) begin
          lo = mid;
        end else begin
          hi = mid - (POW_W+2)'(1);
        end
      end
    end
    return lo[POW_W-1:0];
  endfunction

endpackage

@@ hw/rtl/piecewise_lux_from_two_channels_unit.sv @@
// ============================================================================
// piecewise_lux_from_two_channels_unit
// Piecewise lux from a broadband and an infrared count, fixed-point result.
// ============================================================================
// Stages: 1 classify stage, 9 ratio divider stages, 4 fit stages and
//   2 reciprocal multiply stages between transaction in and result out.
// Throughput: one transaction per cycle while the output is not back-pressured;
//   every stage is registered and empty stages close up under output back-pressure.
// Reset: asynchronous, active low; clears the stage valid bits only.
module piecewise_lux_from_two_channels_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [plux_pkg::CNT_W-1:0] broadband_count_i,
  input  logic [plux_pkg::CNT_W-1:0] infrared_count_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [plux_pkg::LUX_W-1:0] lux_fixed_o
);
  import plux_pkg::*;

  logic             cls_valid;
  logic             cls_ready;
  plux_side_t       cls_side;
  logic [DVD_W-1:0] cls_dvd;
  logic [DSR_W-1:0] cls_dsr;

  logic             div_valid;
  logic             div_ready;
  plux_side_t       div_side;
  logic [IDX_W-1:0] div_idx;

  logic             fit_valid;
  logic             fit_ready;
  logic [Y_W-1:0]   fit_y;
  logic             fit_sat;

  plux_classify u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .ch0_i   (broadband_count_i),
    .ch1_i   (infrared_count_i),
    .valid_o (cls_valid),
    .ready_i (cls_ready),
    .side_o  (cls_side),
    .dvd_o   (cls_dvd),
    .dsr_o   (cls_dsr)
  );

  plux_ratio_div u_ratio_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cls_valid),
    .ready_o (cls_ready),
    .side_i  (cls_side),
    .dvd_i   (cls_dvd),
    .dsr_i   (cls_dsr),
    .valid_o (div_valid),
    .ready_i (div_ready),
    .side_o  (div_side),
    .idx_o   (div_idx)
  );

  plux_fit u_fit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .ready_o (div_ready),
    .side_i  (div_side),
    .idx_i   (div_idx),
    .valid_o (fit_valid),
    .ready_i (fit_ready),
    .y_o     (fit_y),
    .sat_o   (fit_sat)
  );

  plux_lux_div u_lux_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fit_valid),
    .ready_o (fit_ready),
    .y_i     (fit_y),
    .sat_i   (fit_sat),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .lux_o   (lux_fixed_o)
  );

  // an empty output stage lets every stage advance, so input is never held
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output stage is empty");

endmodule

@@ hw/rtl/plux_classify.sv @@
// ============================================================================
// plux_classify
// Input stage: picks the ratio region with exact integer compares and forms
// the dividend and divisor for the ratio index.
// ============================================================================
module plux_classify (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [plux_pkg::CNT_W-1:0] ch0_i,
  input  logic [plux_pkg::CNT_W-1:0] ch1_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output plux_pkg::plux_side_t       side_o,
  output logic [plux_pkg::DVD_W-1:0] dvd_o,
  output logic [plux_pkg::DSR_W-1:0] dsr_o
);
  import plux_pkg::*;

  localparam int unsigned CMP_W = CNT_W + 7;

  logic                 v_q;
  logic                 en;
  region_e              region_d;
  logic [CMP_W-1:0]     a0;
  logic [CMP_W-1:0]     a1;
  plux_side_t           side_q;
  logic [DVD_W-1:0]     dvd_q;
  logic [DSR_W-1:0]     dsr_q;

  assign en      = ready_i | ~v_q;
  assign ready_o = en;

  assign a0 = CMP_W'(ch0_i);
  assign a1 = CMP_W'(ch1_i);

  // each bound belongs to the region below it
  always_comb begin
    if (ch0_i == '0 || ch1_i == '0) begin
      region_d = REG_ZERO;
    end else if ((a1 << 1) <= a0) begin
      region_d = REG_POW;
    end else if (a1 * CMP_W'(100) <= a0 * CMP_W'(61)) begin
      region_d = REG_R61;
    end else if (a1 * CMP_W'(5) <= a0 * CMP_W'(4)) begin
      region_d = REG_R80;
    end else if (a1 * CMP_W'(10) <= a0 * CMP_W'(13)) begin
      region_d = REG_R130;
    end else begin
      region_d = REG_ZERO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q.ch0    <= ch0_i;
      side_q.ch1    <= ch1_i;
      side_q.region <= region_d;
      dvd_q         <= DVD_W'(ch1_i) * DVD_W'(2 * RATIO_N) + DVD_W'(ch0_i);
      dsr_q         <= {ch0_i, 1'b0};
    end
  end

  assign valid_o = v_q;
  assign side_o  = side_q;
  assign dvd_o   = dvd_q;
  assign dsr_o   = dsr_q;

  a_zero_count_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (side_o.ch0 == '0 || side_o.ch1 == '0) |-> side_o.region == REG_ZERO)
    else $error("zero count not mapped to zero region");

endmodule

@@ hw/rtl/plux_ratio_div.sv @@
// ============================================================================
// plux_ratio_div
// Restoring divider for the rounded ratio index, one quotient bit per
// pipeline stage; region and counts ride along.
// ============================================================================
module plux_ratio_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  plux_pkg::plux_side_t       side_i,
  input  logic [plux_pkg::DVD_W-1:0] dvd_i,
  input  logic [plux_pkg::DSR_W-1:0] dsr_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output plux_pkg::plux_side_t       side_o,
  output logic [plux_pkg::IDX_W-1:0] idx_o
);
  import plux_pkg::*;

  localparam int unsigned S = IDX_W;

  logic [S-1:0]     v_q;
  logic [S-1:0]     v_in;
  logic [S-1:0]     en;
  logic [DVD_W-1:0] rem_q  [S-1];
  logic [DSR_W-1:0] dsr_q  [S-1];
  logic [IDX_W-1:0] q_q    [S];
  plux_side_t       side_q [S];

  assign v_in    = {v_q[S-2:0], valid_i};
  assign ready_o = en[0];

  for (genvar s = 0; s < S; s++) begin : g_stage
    localparam int unsigned B = S - 1 - s;
    logic [DVD_W-1:0] rem_in;
    logic [DSR_W-1:0] dsr_in;
    logic [IDX_W-1:0] q_in;
    plux_side_t       side_in;
    logic [DIV_W-1:0] sub;
    logic             take;

    // a stage moves when any stage from here on is empty or the sink takes
    assign en[s] = ready_i | ~(&v_q[S-1:s]);

    if (s == 0) begin : g_first
      assign rem_in  = dvd_i;
      assign dsr_in  = dsr_i;
      assign q_in    = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign dsr_in  = dsr_q[s-1];
      assign q_in    = q_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign sub  = DIV_W'(dsr_in) << B;
    assign take = DIV_W'(rem_in) >= sub;

    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        q_q[s]    <= take ? (q_in | (IDX_W'(1) << B)) : q_in;
        side_q[s] <= side_in;
      end
    end

    if (s < S - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en[s]) begin
          rem_q[s] <= take ? DVD_W'(DIV_W'(rem_in) - sub) : rem_in;
          dsr_q[s] <= dsr_in;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < S; s++) begin
        if (en[s]) begin
          v_q[s] <= v_in[s];
        end
      end
    end
  end

  assign valid_o = v_q[S-1];
  assign side_o  = side_q[S-1];
  assign idx_o   = q_q[S-1];

  a_index_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && side_o.region == REG_POW |-> idx_o <= IDX_W'(POWER_TABLE_DEPTH))
    else $error("ratio index beyond power table in lowest region");

endmodule

@@ hw/rtl/plux_fit.sv @@
// ============================================================================
// plux_fit
// Region fit: power table read, coefficient and linear terms, the product
// with the broadband count, then scaling and rounding offset.
// ============================================================================
module plux_fit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  plux_pkg::plux_side_t       side_i,
  input  logic [plux_pkg::IDX_W-1:0] idx_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [plux_pkg::Y_W-1:0]   y_o,
  output logic                       sat_o
);
  import plux_pkg::*;

  localparam int unsigned S = 4;
  localparam logic [POW_W-1:0] POW_LAST = pow_entry(POWER_TABLE_DEPTH);

  logic [S-1:0]        v_q;
  logic [S-1:0]        v_in;
  logic [S-1:0]        en;
  logic [POW_W-1:0]    pow_rom [POWER_TABLE_DEPTH];

  logic [POW_W-1:0]    p_d;
  logic [POW_W-1:0]    a_p_q;
  plux_side_t          a_side_q;

  logic [LIN_CW-1:0]   coef_a;
  logic [LIN_CW-1:0]   coef_b;
  logic [LIN_W-1:0]    prod_a;
  logic [LIN_W-1:0]    prod_b;
  logic [COEF_W:0]     b_coef_q;
  logic [LIN_W-1:0]    b_lin_q;
  logic [CNT_W-1:0]    b_ch0_q;
  region_e             b_region_q;

  logic [NUM_W-1:0]    num_d;
  logic [NUM_W-1:0]    c_num_q;
  logic                c_pow_q;

  logic [X_W-1:0]      x_full;
  logic [X_W-1:0]      y_full;
  logic [Y_W-1:0]      d_y_q;
  logic                d_sat_q;

  for (genvar g = 0; g < POWER_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [POW_W-1:0] ENTRY = pow_entry(g);
    assign pow_rom[g] = ENTRY;
  end

  for (genvar s = 0; s < S; s++) begin : g_en
    assign en[s] = ready_i | ~(&v_q[S-1:s]);
  end

  assign v_in    = {v_q[S-2:0], valid_i};
  assign ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < S; s++) begin
        if (en[s]) begin
          v_q[s] <= v_in[s];
        end
      end
    end
  end

  // table read; an index at or beyond the table depth takes the entry for index POWER_TABLE_DEPTH
  assign p_d = (idx_i >= IDX_W'(POWER_TABLE_DEPTH)) ? POW_LAST : pow_rom[idx_i[TAB_W-1:0]];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_p_q    <= p_d;
      a_side_q <= side_i;
    end
  end

  always_comb begin
    case (a_side_q.region)
      REG_R61: begin
        coef_a = LIN_A61;
        coef_b = LIN_B61;
      end
      REG_R80: begin
        coef_a = LIN_A80;
        coef_b = LIN_B80;
      end
      REG_R130: begin
        coef_a = LIN_A130;
        coef_b = LIN_B130;
      end
      default: begin
        coef_a = '0;
        coef_b = '0;
      end
    endcase
  end

  assign prod_a = LIN_W'(a_side_q.ch0) * LIN_W'(coef_a);
  assign prod_b = LIN_W'(a_side_q.ch1) * LIN_W'(coef_b);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      b_coef_q   <= POW_BASE - (COEF_W+1)'(a_p_q) * POW_SLOPE;
      b_lin_q    <= prod_a - prod_b;
      b_ch0_q    <= a_side_q.ch0;
      b_region_q <= a_side_q.region;
    end
  end

  // drop non-positive fits to zero
  always_comb begin
    if (b_region_q == REG_POW) begin
      if (!b_coef_q[COEF_W] && b_coef_q != '0) begin
        num_d = NUM_W'(b_coef_q[COEF_W-1:0]) * NUM_W'(b_ch0_q);
      end else begin
        num_d = '0;
      end
    end else if (!b_lin_q[LIN_W-1] && b_lin_q != '0) begin
      num_d = NUM_W'(b_lin_q[LIN_W-2:0]);
    end else begin
      num_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      c_num_q <= num_d;
      c_pow_q <= (b_region_q == REG_POW);
    end
  end

  // divisor is 3125 * 2^shift: take the power of two here, 3125 downstream
  assign x_full = (X_W'(c_num_q) << SCALE_SH) + (c_pow_q ? HALF_POW : HALF_LIN);
  assign y_full = c_pow_q ? (x_full >> POW_SH) : (x_full >> LIN_SH);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      d_y_q   <= y_full[Y_W-1:0];
      d_sat_q <= (y_full >= SAT_LIMIT);
    end
  end

  assign valid_o = v_q[S-1];
  assign y_o     = d_y_q;
  assign sat_o   = d_sat_q;

  a_zero_region_num: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] && en[2] && b_region_q == REG_ZERO |=> c_num_q == '0)
    else $error("zero region produced a nonzero fit");

endmodule

@@ hw/rtl/plux_lux_div.sv @@
// ============================================================================
// plux_lux_div
// Division of the scaled fit by 3125 as a reciprocal multiply split into
// half-width products, with saturation at the top of the lux range.
// ============================================================================
module plux_lux_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [plux_pkg::Y_W-1:0]   y_i,
  input  logic                       sat_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [plux_pkg::LUX_W-1:0] lux_o
);
  import plux_pkg::*;

  localparam int unsigned S     = 2;
  localparam int unsigned HW    = RECIP_W / 2;
  localparam int unsigned PP_W  = 2 * HW;
  localparam int unsigned SUM_W = Y_W + RECIP_W;
  localparam logic [HW-1:0] R_LO = RECIP[HW-1:0];
  localparam logic [HW-1:0] R_HI = RECIP[RECIP_W-1:HW];

  logic [S-1:0]     v_q;
  logic [S-1:0]     v_in;
  logic [S-1:0]     en;
  logic [HW-1:0]    y_lo;
  logic [HW-1:0]    y_hi;
  logic [PP_W-1:0]  pp_ll_q;
  logic [PP_W-1:0]  pp_lh_q;
  logic [PP_W-1:0]  pp_hl_q;
  logic [PP_W-1:0]  pp_hh_q;
  logic             sat_q;
  logic [SUM_W-1:0] sum;
  logic [LUX_W-1:0] lux_q;

  assign v_in    = {v_q[S-2:0], valid_i};
  assign ready_o = en[0];

  for (genvar s = 0; s < S; s++) begin : g_en
    assign en[s] = ready_i | ~(&v_q[S-1:s]);
  end

  assign y_lo = y_i[HW-1:0];
  assign y_hi = HW'(y_i >> HW);

  // split y * RECIP into four half-width products
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      pp_ll_q <= PP_W'(y_lo) * PP_W'(R_LO);
      pp_lh_q <= PP_W'(y_lo) * PP_W'(R_HI);
      pp_hl_q <= PP_W'(y_hi) * PP_W'(R_LO);
      pp_hh_q <= PP_W'(y_hi) * PP_W'(R_HI);
      sat_q   <= sat_i;
    end
  end

  assign sum = (SUM_W'(pp_hh_q) << PP_W) + (SUM_W'(pp_hl_q) << HW) +
               (SUM_W'(pp_lh_q) << HW) + SUM_W'(pp_ll_q);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      lux_q <= sat_q ? LUX_MAX : sum[RECIP_SH +: LUX_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < S; s++) begin
        if (en[s]) begin
          v_q[s] <= v_in[s];
        end
      end
    end
  end

  assign valid_o = v_q[S-1];
  assign lux_o   = lux_q;

endmodule
